### src/rsmp_pkg.sv
// Package for the linear interpolation resampler: field widths, payload structs,
// configuration register indexes, sequencer states and lane control bundle.
// No dependencies; compile first.
package rsmp_pkg;

	localparam int SAMPLE_W = 32;
	localparam int DIFF_W   = SAMPLE_W + 1;
	localparam int RATE_W   = 20;
	localparam int PHASE_W  = RATE_W + 1;
	localparam int CCOUNT_W = 4;
	localparam int NUM_CH   = 8;
	localparam int STEP_W   = $clog2(DIFF_W);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = RATE_W;

	localparam logic [RATE_W-1:0]   IN_RATE_RST  = RATE_W'(48000);
	localparam logic [RATE_W-1:0]   OUT_RATE_RST = RATE_W'(44100);
	localparam logic [CCOUNT_W-1:0] CCOUNT_RST   = CCOUNT_W'(2);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IN_RATE       = 2'd0,
		CFG_OUT_RATE      = 2'd1,
		CFG_CHANNEL_COUNT = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CALC,
		ST_SUM,
		ST_EMIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_ch0;
		logic signed [SAMPLE_W-1:0] sample_ch1;
		logic signed [SAMPLE_W-1:0] sample_ch2;
		logic signed [SAMPLE_W-1:0] sample_ch3;
		logic signed [SAMPLE_W-1:0] sample_ch4;
		logic signed [SAMPLE_W-1:0] sample_ch5;
		logic signed [SAMPLE_W-1:0] sample_ch6;
		logic signed [SAMPLE_W-1:0] sample_ch7;
		logic                       restart;
	} in_frame_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_ch0;
		logic signed [SAMPLE_W-1:0] out_ch1;
		logic signed [SAMPLE_W-1:0] out_ch2;
		logic signed [SAMPLE_W-1:0] out_ch3;
		logic signed [SAMPLE_W-1:0] out_ch4;
		logic signed [SAMPLE_W-1:0] out_ch5;
		logic signed [SAMPLE_W-1:0] out_ch6;
		logic signed [SAMPLE_W-1:0] out_ch7;
		logic                       last_of_run;
	} out_frame_t;

	// Per-lane strobes from the sequencer.
	typedef struct packed {
		logic capture;  // load the current frame sample
		logic start;    // form |cur - prev| and clear the divider
		logic step;     // one bit of the serial multiply-divide
		logic finish;   // add the signed quotient to the previous sample
		logic commit;   // current sample becomes the previous sample
	} lane_ctl_t;

endpackage

### src/rsmp_lane.sv
// One channel lane of the resampler: holds current and previous samples and
// computes prev + trunc((cur - prev) * phase / rate) one bit per cycle.
// Depends on rsmp_pkg.
module rsmp_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rsmp_pkg::lane_ctl_t                 ctl,
	input  logic                                active,
	input  logic signed [rsmp_pkg::SAMPLE_W-1:0] sample,
	input  logic [rsmp_pkg::RATE_W-1:0]          phase,
	input  logic [rsmp_pkg::RATE_W-1:0]          rate,
	output logic signed [rsmp_pkg::SAMPLE_W-1:0] result
);
	import rsmp_pkg::*;

	logic signed [SAMPLE_W-1:0] cur_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic signed [SAMPLE_W-1:0] y_q;
	logic [DIFF_W-1:0]          mag_q;
	logic [DIFF_W-1:0]          quo_q;
	logic [RATE_W-1:0]          rem_q;
	logic                       neg_q;

	logic [DIFF_W-1:0]   diff;
	logic [DIFF_W-1:0]   diff_abs;
	logic [RATE_W+1:0]   part;
	logic [RATE_W+1:0]   one_r;
	logic [RATE_W+1:0]   two_r;
	logic [RATE_W+1:0]   rem_n;
	logic [1:0]          k;
	logic [DIFF_W-1:0]   quo_n;
	logic [DIFF_W-1:0]   quo_s;
	logic [DIFF_W-1:0]   y_n;

	assign diff     = {cur_q[SAMPLE_W-1], cur_q} - {prev_q[SAMPLE_W-1], prev_q};
	assign diff_abs = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;

	// Remainder stays below rate; 2*rem + phase stays below 3*rate.
	assign part  = {1'b0, rem_q, 1'b0} + (mag_q[DIFF_W-1] ? {2'b00, phase} : '0);
	assign one_r = {2'b00, rate};
	assign two_r = {1'b0, rate, 1'b0};

	always_comb begin
		if (part >= two_r) begin
			rem_n = part - two_r;
			k     = 2'd2;
		end else if (part >= one_r) begin
			rem_n = part - one_r;
			k     = 2'd1;
		end else begin
			rem_n = part;
			k     = 2'd0;
		end
	end

	assign quo_n = {quo_q[DIFF_W-2:0], 1'b0} + {{(DIFF_W-2){1'b0}}, k};
	assign quo_s = neg_q ? (~quo_q + DIFF_W'(1)) : quo_q;
	assign y_n   = {prev_q[SAMPLE_W-1], prev_q} + quo_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (ctl.commit && active) begin
			prev_q <= cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cur_q <= sample;
		end
		if (ctl.start) begin
			mag_q <= diff_abs;
			neg_q <= diff[DIFF_W-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (ctl.step) begin
			mag_q <= {mag_q[DIFF_W-2:0], 1'b0};
			rem_q <= rem_n[RATE_W-1:0];
			quo_q <= quo_n;
		end
		if (ctl.finish) begin
			y_q <= active ? y_n[SAMPLE_W-1:0] : '0;
		end
	end

	assign result = y_q;

endmodule

### src/linear_interp_resampler_core.sv
// Top level of the linear interpolation sample rate converter: sequencer,
// rate registers, phase accumulator, channel lanes and result register.
// Depends on rsmp_pkg and rsmp_lane.
//
//  channel   handshake                  payload                  direction
//  -------   -------------------------  -----------------------  ---------
//  source    src_valid / src_stall      src_frame (in_frame_t)   into core
//  result    res_valid / res_stall      res_frame (out_frame_t)  out of core
//  config    cfg_wr_en                  cfg_index / cfg_data     into core
//
// Each result frame passes ST_CHECK to test the phase, ST_CALC for the
// bit-serial multiply-divide (one bit of the 33-bit difference per cycle, all
// channel lanes in parallel), ST_SUM to sum and ST_EMIT to emit; ST_EMIT waits
// for a free result register. Every item ends in ST_FINISH, which a restart
// item enters straight from ST_IDLE. Reset clears the rate registers to their
// defaults, the phase, previous frame and all handshake state. A stalled result
// register holds the next frame in its lane registers until the transfer
// completes; src_stall stays high for the whole run of an item.
module linear_interp_resampler_core #(
	parameter int MAX_CHANNELS = 8,
	parameter int MAX_RUN      = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                src_valid,
	output logic                                src_stall,
	input  rsmp_pkg::in_frame_t                 src_frame,
	output logic                                res_valid,
	input  logic                                res_stall,
	output rsmp_pkg::out_frame_t                res_frame,
	input  logic                                cfg_wr_en,
	input  logic [rsmp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rsmp_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rsmp_pkg::*;

	localparam int CNT_W = $clog2(MAX_RUN + 1);

	state_t state_q, state_n;

	logic [RATE_W-1:0]   in_rate_q;
	logic [RATE_W-1:0]   out_rate_q;
	logic [CCOUNT_W-1:0] ch_count_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [CNT_W-1:0]    run_cnt_q;
	logic [STEP_W-1:0]   step_q;
	logic                restart_q;
	logic                last_q;
	logic                res_valid_q;
	out_frame_t          res_frame_q;

	logic                src_xfer;
	logic                res_free;
	logic                go;
	logic [PHASE_W-1:0]  phase_next;
	logic                last_n;
	lane_ctl_t           lane_ctl;

	logic signed [SAMPLE_W-1:0] sample_arr [NUM_CH];
	logic signed [SAMPLE_W-1:0] y_arr      [NUM_CH];

	assign src_xfer = src_valid && !src_stall;
	// Result register takes a new frame when empty or when its transfer completes.
	assign res_free = !res_valid_q || !res_stall;

	// Emit while the phase is below the output rate and the run limit is not hit.
	assign go         = (phase_q < {1'b0, out_rate_q}) && (run_cnt_q < CNT_W'(MAX_RUN));
	assign phase_next = phase_q + {1'b0, in_rate_q};
	assign last_n     = !((phase_next < {1'b0, out_rate_q}) &&
		(run_cnt_q < CNT_W'(MAX_RUN - 1)));

	assign sample_arr[0] = src_frame.sample_ch0;
	assign sample_arr[1] = src_frame.sample_ch1;
	assign sample_arr[2] = src_frame.sample_ch2;
	assign sample_arr[3] = src_frame.sample_ch3;
	assign sample_arr[4] = src_frame.sample_ch4;
	assign sample_arr[5] = src_frame.sample_ch5;
	assign sample_arr[6] = src_frame.sample_ch6;
	assign sample_arr[7] = src_frame.sample_ch7;

	// Channel lanes; channels past MAX_CHANNELS always read zero.
	for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
		if (c < MAX_CHANNELS) begin : g_on
			rsmp_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (lane_ctl),
				.active (ch_count_q > CCOUNT_W'(c)),
				.sample (sample_arr[c]),
				.phase  (phase_q[RATE_W-1:0]),
				.rate   (out_rate_q),
				.result (y_arr[c])
			);
		end else begin : g_off
			assign y_arr[c] = '0;
		end
	end

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (src_xfer) begin
					state_n = src_frame.restart ? ST_FINISH : ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_n = go ? ST_CALC : ST_FINISH;
			end
			ST_CALC: begin
				if (step_q == STEP_W'(DIFF_W - 1)) begin
					state_n = ST_SUM;
				end
			end
			ST_SUM: begin
				state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (res_free) begin
					state_n = ST_CHECK;
				end
			end
			ST_FINISH: begin
				state_n = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer; capture the frame on the idle-state transfer.
	always_comb begin
		src_stall = 1'b1;
		lane_ctl  = '0;
		case (state_q)
			ST_IDLE: begin
				src_stall        = 1'b0;
				lane_ctl.capture = src_valid;
			end
			ST_CHECK:  lane_ctl.start = go;
			ST_CALC:   lane_ctl.step  = 1'b1;
			ST_SUM:    lane_ctl.finish = 1'b1;
			ST_FINISH: lane_ctl.commit = 1'b1;
			default:   src_stall      = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_rate_q   <= IN_RATE_RST;
			out_rate_q  <= OUT_RATE_RST;
			ch_count_q  <= CCOUNT_RST;
			phase_q     <= '0;
			run_cnt_q   <= '0;
			step_q      <= '0;
			restart_q   <= 1'b0;
			last_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;

			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_IN_RATE:       in_rate_q  <= cfg_data;
					CFG_OUT_RATE:      out_rate_q <= cfg_data;
					CFG_CHANNEL_COUNT: ch_count_q <= cfg_data[CCOUNT_W-1:0];
					default:           ;
				endcase
			end

			if (src_xfer) begin
				restart_q <= src_frame.restart;
				run_cnt_q <= '0;
			end

			if (state_q == ST_CHECK && go) begin
				step_q <= '0;
				last_q <= last_n;
			end else if (state_q == ST_CALC) begin
				step_q <= step_q + STEP_W'(1);
			end

			// Advance the phase by the input rate for each emitted frame.
			if (state_q == ST_EMIT && res_free) begin
				phase_q   <= phase_next;
				run_cnt_q <= run_cnt_q + CNT_W'(1);
			end

			// Drop one output period from the phase, or clear it on restart or
			// when the run limit cut the run short.
			if (state_q == ST_FINISH) begin
				if (restart_q) begin
					phase_q <= '0;
				end else if (phase_q >= {1'b0, out_rate_q}) begin
					phase_q <= phase_q - {1'b0, out_rate_q};
				end else begin
					phase_q <= '0;
				end
			end

			if (state_q == ST_EMIT && res_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && res_free) begin
			res_frame_q.out_ch0     <= y_arr[0];
			res_frame_q.out_ch1     <= y_arr[1];
			res_frame_q.out_ch2     <= y_arr[2];
			res_frame_q.out_ch3     <= y_arr[3];
			res_frame_q.out_ch4     <= y_arr[4];
			res_frame_q.out_ch5     <= y_arr[5];
			res_frame_q.out_ch6     <= y_arr[6];
			res_frame_q.out_ch7     <= y_arr[7];
			res_frame_q.last_of_run <= last_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_frame = res_frame_q;

endmodule

### src/rsmp_checker.sv
// Port-level checker for the resampler core, bound to the top level.
// Depends on rsmp_pkg and linear_interp_resampler_core.
module rsmp_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 src_valid,
	input logic                 src_stall,
	input rsmp_pkg::in_frame_t  src_frame,
	input logic                 res_valid,
	input logic                 res_stall,
	input rsmp_pkg::out_frame_t res_frame
);
	import rsmp_pkg::*;

	// A stalled result holds its frame.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_frame))
		else $error("stalled result changed");

	// One item at a time: after a source transfer the core stalls its input.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall |=> src_stall)
		else $error("source accepted while busy");

	// A new result appears only while an item is being worked on.
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> src_stall)
		else $error("result appeared with no item in flight");

	// A frame that is not the last of its run means the run is still going.
	a_run_open: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_frame.last_of_run |-> src_stall)
		else $error("input taken before run ended");

	// A restart item produces no result frame right after it.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall && src_frame.restart && !res_valid |=> !res_valid)
		else $error("restart produced a result");

endmodule

bind linear_interp_resampler_core rsmp_checker u_rsmp_checker (.*);
